// ----- src/sters_pkg.sv -----
// Package for the sorted table equal-range search unit.
// Holds field widths, action codes, sequencer states and the compare result type.
// No dependencies.
`default_nettype none

package sters_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 32;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_BS_CMP,
    ST_LO_ISSUE,
    ST_LO_CMP,
    ST_HI_ISSUE,
    ST_HI_CMP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

`default_nettype wire

// ----- src/sters_if.sv -----
// Channel interfaces for the sorted table equal-range search unit.
// Depends on sters_pkg for field widths.
`default_nettype none

interface sters_in_if;
  import sters_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;
  logic                    last_element;

  modport source (output valid, action, index, value, last_element, input ready);
  modport sink (input valid, action, index, value, last_element, output ready);
endinterface

interface sters_out_if;
  import sters_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] first_index;
  logic [IDX_W-1:0] last_index;

  modport source (output valid, found, first_index, last_index, input ready);
  modport sink (input valid, found, first_index, last_index, output ready);
endinterface

`default_nettype wire

// ----- src/sters_cmp.sv -----
// Shared signed comparator used by every probe of the search.
// Depends on sters_pkg for widths and the compare result type.
`default_nettype none

module sters_cmp (
  input  wire logic signed [sters_pkg::VAL_W-1:0] entry,
  input  wire logic signed [sters_pkg::VAL_W-1:0] target,
  output sters_pkg::cmp_res_t                     res
);
  import sters_pkg::*;

  always_comb begin
    res.eq = (entry == target);
    res.lt = (entry < target);
  end

endmodule

`default_nettype wire

// ----- src/sorted_table_equal_range_search_unit.sv -----
// Top level of the sorted table equal-range search unit: table memory and search sequencer.
// Depends on sters_pkg, the channel interfaces in sters_if and the comparator sters_cmp.
//
//   Channel  Dir  Fields                                   Handshake
//   in_ch    in   action, index, value, last_element       valid/ready
//   out_ch   out  found, first_index, last_index           valid/ready
//
// A load item is taken without leaving the idle state and produces no result.
// A query runs P binary-search probes and then reads R neighbors, where P is the number of
// probes (at most ceil(log2(count+1))) and R the number of neighbors examined while extending
// the equal run; each probe is one read of the single-port table memory.
// The input is ready only while the sequencer is idle; a finished result waits in the output
// register, and a new query may run meanwhile. Reset empties the table by clearing the element count.
`default_nettype none

module sorted_table_equal_range_search_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sters_in_if.sink    in_ch,
  sters_out_if.source out_ch
);
  import sters_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  logic [VAL_W-1:0] mem [TABLE_DEPTH];

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        left_r, left_nxt;
  logic [CNT_W-1:0]        hi_r, hi_nxt;
  logic [CNT_W-1:0]        mid_r, mid_nxt;
  logic [ADDR_W-1:0]       run_lo_r, run_lo_nxt;
  logic [ADDR_W-1:0]       run_hi_r, run_hi_nxt;
  logic                    hit_r, hit_nxt;
  logic signed [VAL_W-1:0] target_r, target_nxt;
  logic signed [VAL_W-1:0] rd_data_r;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r, out_found_nxt;
  logic [IDX_W-1:0]        out_first_r, out_first_nxt;
  logic [IDX_W-1:0]        out_last_r, out_last_nxt;

  logic              in_accept;
  logic              load_ok;
  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  span;
  logic [CNT_W-1:0]  mid;
  cmp_res_t          cmp;

  sters_cmp u_cmp (
    .entry  (rd_data_r),
    .target (target_r),
    .res    (cmp)
  );

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign in_accept          = in_ch.valid && in_ch.ready;
  assign load_ok            = (32'(in_ch.index) < TABLE_DEPTH);
  assign wr_en              = in_accept && (in_ch.action == ACT_LOAD) && load_ok;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.first_index = out_first_r;
  assign out_ch.last_index  = out_last_r;

  assign span = hi_r - left_r - CNT_W'(1);
  assign mid  = left_r + (span >> 1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ADDR_W'(in_ch.index)] <= in_ch.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r      <= left_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    run_lo_r    <= run_lo_nxt;
    run_hi_r    <= run_hi_nxt;
    hit_r       <= hit_nxt;
    target_r    <= target_nxt;
    out_found_r <= out_found_nxt;
    out_first_r <= out_first_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    left_nxt      = left_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    run_lo_nxt    = run_lo_r;
    run_hi_nxt    = run_hi_r;
    hit_nxt       = hit_r;
    target_nxt    = target_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_first_nxt = out_first_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_ch.action == ACT_QUERY) begin
            target_nxt = in_ch.value;
            left_nxt   = '0;
            hi_nxt     = count_r;
            state_nxt  = ST_PROBE;
          end else if (load_ok && in_ch.last_element) begin
            count_nxt = CNT_W'(in_ch.index) + CNT_W'(1);
          end
        end
      end
      ST_PROBE: begin
        if (left_r < hi_r) begin
          rd_en     = 1'b1;
          rd_addr   = ADDR_W'(mid);
          mid_nxt   = mid;
          state_nxt = ST_BS_CMP;
        end else begin
          hit_nxt    = 1'b0;
          run_lo_nxt = '0;
          run_hi_nxt = '0;
          state_nxt  = ST_RESULT;
        end
      end
      ST_BS_CMP: begin
        if (cmp.eq) begin
          hit_nxt    = 1'b1;
          run_lo_nxt = ADDR_W'(mid_r);
          run_hi_nxt = ADDR_W'(mid_r);
          state_nxt  = ST_LO_ISSUE;
        end else if (cmp.lt) begin
          left_nxt  = mid_r + CNT_W'(1);
          state_nxt = ST_PROBE;
        end else begin
          hi_nxt    = mid_r;
          state_nxt = ST_PROBE;
        end
      end
      ST_LO_ISSUE: begin
        if (run_lo_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = run_lo_r - ADDR_W'(1);
          state_nxt = ST_LO_CMP;
        end else begin
          state_nxt = ST_HI_ISSUE;
        end
      end
      ST_LO_CMP: begin
        if (cmp.eq) begin
          run_lo_nxt = run_lo_r - ADDR_W'(1);
          state_nxt  = ST_LO_ISSUE;
        end else begin
          state_nxt = ST_HI_ISSUE;
        end
      end
      ST_HI_ISSUE: begin
        if ((CNT_W'(run_hi_r) + CNT_W'(1)) < count_r) begin
          rd_en     = 1'b1;
          rd_addr   = run_hi_r + ADDR_W'(1);
          state_nxt = ST_HI_CMP;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_HI_CMP: begin
        if (cmp.eq) begin
          run_hi_nxt = run_hi_r + ADDR_W'(1);
          state_nxt  = ST_HI_ISSUE;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = hit_r;
          out_first_nxt = IDX_W'(run_lo_r);
          out_last_nxt  = IDX_W'(run_hi_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= TABLE_DEPTH)
    else $error("Element count exceeds the table depth.");

  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (left_r <= hi_r) && (hi_r <= count_r))
    else $error("Search bounds out of order.");

  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_ch.action == ACT_QUERY) |=> (state_r == ST_PROBE))
    else $error("Accepted query did not start a search.");

  a_run_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.found |-> (out_ch.first_index <= out_ch.last_index))
    else $error("Reported run has first index above last index.");

endmodule

`default_nettype wire

// ----- tb/sorted_table_equal_range_search_unit_tb.sv -----
// Testbench for the sorted table equal-range search unit.
// It mirrors the table, predicts the found flag and the equal run of each query, and checks
// every result in order. Depends on sters_pkg, the channel interfaces and the unit itself.
`default_nettype none

module sorted_table_equal_range_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sters_pkg::*;

  localparam int TABLE_DEPTH  = 1024;
  localparam int RANDOM_ITEMS = 1650;
  localparam int N_DIR        = 25;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 64;

  localparam logic signed [VAL_W-1:0] MIN_VAL = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] MAX_VAL = 32'sh7fff_ffff;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
  } match_t;

  localparam match_t MISS = '0;

  typedef enum logic [1:0] {CHK_NONE, CHK_MODEL, CHK_FIXED} check_kind_t;

  typedef struct {
    logic                    act;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] val;
    logic                    last_el;
    check_kind_t             kind;
    match_t                  fixed;
  } dir_row_t;

  logic clk;
  logic rst_n;

  sters_in_if  in_ch ();
  sters_out_if out_ch ();

  sorted_table_equal_range_search_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic signed [VAL_W-1:0] mirror_vals [TABLE_DEPTH];
  bit                      mirror_written [TABLE_DEPTH];
  int                      mirror_count;
  match_t                  pending_ranges [$];

  int errors;
  int items_sent;
  int loads_sent;
  int queries_sent;
  int results_seen;
  int hits_seen;
  int misses_seen;
  int largest_table;
  int burst_left;
  int hold_left;
  bit held_once;
  int rx_phase;
  int rx_mode;

  dir_row_t dir_rows [N_DIR];

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  function automatic match_t search_range(input logic signed [VAL_W-1:0] target);
    int     left;
    int     right;
    int     mid;
    int     lo;
    int     hi;
    bit     hit_ok;
    match_t m;
    m = MISS;
    left = 0;
    right = mirror_count - 1;
    mid = 0;
    hit_ok = 1'b0;
    while (left <= right && !hit_ok) begin
      mid = left + (right - left) / 2;
      if (mirror_vals[mid] == target) hit_ok = 1'b1;
      else if (mirror_vals[mid] < target) left = mid + 1;
      else right = mid - 1;
    end
    if (hit_ok) begin
      lo = mid;
      hi = mid;
      while (lo > 0 && mirror_vals[lo-1] == target) lo--;
      while (hi + 1 < mirror_count && mirror_vals[hi+1] == target) hi++;
      m.found = 1'b1;
      m.first_index = IDX_W'(lo);
      m.last_index = IDX_W'(hi);
    end
    return m;
  endfunction

  function automatic bit count_fully_written();
    for (int i = 0; i < mirror_count; i++) begin
      if (!mirror_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int draw_value(input int mode, input int base);
    case (mode)
      0: return base + int'($urandom_range(0, 7));
      1: return int'($urandom);
      2: begin
        case ($urandom_range(0, 6))
          0: return int'(MIN_VAL);
          1: return int'(MIN_VAL) + 1;
          2: return -1;
          3: return 0;
          4: return 1;
          5: return int'(MAX_VAL) - 1;
          default: return int'(MAX_VAL);
        endcase
      end
      default: return (int'($urandom_range(0, 2000)) - 1000) * 1000;
    endcase
  endfunction

  task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
                           input logic signed [VAL_W-1:0] val, input logic last_el,
                           input check_kind_t kind, input match_t fixed);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : int'($urandom_range(1, 12));
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.index        <= idx;
    in_ch.value        <= val;
    in_ch.last_element <= last_el;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
    if (act == ACT_LOAD) begin
      loads_sent++;
      mirror_vals[idx] = val;
      mirror_written[idx] = 1'b1;
      if (last_el) mirror_count = int'(idx) + 1;
      if (mirror_count > largest_table) largest_table = mirror_count;
    end else begin
      queries_sent++;
      pending_ranges.push_back((kind == CHK_FIXED) ? fixed : search_range(val));
    end
  endtask

  task automatic send_query(input logic signed [VAL_W-1:0] target);
    send_item(ACT_QUERY, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), target,
              1'($urandom_range(0, 1)), CHK_MODEL, MISS);
  endtask

  task automatic send_load(input int idx, input int val, input logic last_el);
    send_item(ACT_LOAD, IDX_W'(idx), VAL_W'(val), last_el, CHK_MODEL, MISS);
  endtask

  task automatic table_episode(input int n);
    int vals [$];
    int order [$];
    int mode;
    int base;
    int j;
    int tmp;
    int k;
    int q_total;
    int pick;
    mode = $urandom_range(0, 3);
    base = int'($urandom);
    for (int i = 0; i < n; i++) vals.push_back(draw_value(mode, base));
    if ($urandom_range(0, 7) != 0) vals.sort();
    for (int i = 0; i < n - 1; i++) order.push_back(i);
    for (int i = n - 2; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) begin
      if ($urandom_range(0, 9) == 0) begin
        if (n < TABLE_DEPTH && $urandom_range(0, 1) == 0)
          send_load($urandom_range(n, TABLE_DEPTH - 1), int'($urandom), 1'b0);
        else if (count_fully_written())
          send_query(VAL_W'(draw_value(mode, base)));
      end
      send_load(order[i], vals[order[i]], 1'b0);
    end
    send_load(n - 1, vals[n-1], 1'b1);
    q_total = (n == TABLE_DEPTH) ? 40 : int'($urandom_range(3, 12));
    for (int q = 0; q < q_total; q++) begin
      k = $urandom_range(0, n - 1);
      pick = $urandom_range(0, 7);
      if (pick < 4) send_query(VAL_W'(vals[k]));
      else if (pick == 4) send_query(VAL_W'(vals[k] + ($urandom_range(0, 1) ? 1 : -1)));
      else if (pick == 5) send_query($urandom_range(0, 1) ? MIN_VAL : MAX_VAL);
      else if (pick == 6) send_query(VAL_W'($urandom));
      else send_query(VAL_W'($urandom_range(0, 1) ? vals[0] - 1 : vals[n-1] + 1));
    end
    if ($urandom_range(0, 4) == 0) begin
      k = $urandom_range(0, n - 1);
      send_load(k, vals[k], 1'b1);
      send_query(VAL_W'(vals[$urandom_range(0, n - 1)]));
      send_query(VAL_W'(vals[$urandom_range(0, k)]));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!held_once && results_seen >= 100) begin
      held_once <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_phase == 0) begin
        rx_phase <= $urandom_range(50, 300);
        rx_mode <= $urandom_range(0, 2);
      end else begin
        rx_phase <= rx_phase - 1;
      end
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (out_ch.found) hits_seen++;
      else misses_seen++;
      if (pending_ranges.size() == 0) begin
        $error("result with no query outstanding: found %0d first_index %0d last_index %0d",
               out_ch.found, out_ch.first_index, out_ch.last_index);
        errors++;
      end else begin
        want = pending_ranges.pop_front();
        if (out_ch.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_ch.found);
          errors++;
        end
        if (out_ch.first_index !== want.first_index) begin
          $error("first_index: expected %0d, actual %0d", want.first_index, out_ch.first_index);
          errors++;
        end
        if (out_ch.last_index !== want.last_index) begin
          $error("last_index: expected %0d, actual %0d", want.last_index, out_ch.last_index);
          errors++;
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOAD;
    in_ch.index = '0;
    in_ch.value = '0;
    in_ch.last_element = 1'b0;
    out_ch.ready = 1'b0;
    mirror_count = 0;
    foreach (mirror_written[i]) begin
      mirror_written[i] = 1'b0;
      mirror_vals[i] = '0;
    end

    dir_rows = '{
      '{ACT_QUERY, 10'd0,    32'sd0,         1'b0, CHK_FIXED, MISS},
      '{ACT_QUERY, 10'd1023, MIN_VAL,        1'b1, CHK_FIXED, MISS},
      '{ACT_LOAD,  10'd0,    MIN_VAL,        1'b0, CHK_NONE,  MISS},
      '{ACT_QUERY, 10'd0,    MIN_VAL,        1'b0, CHK_FIXED, MISS},
      '{ACT_LOAD,  10'd1,    -32'sd5,        1'b0, CHK_NONE,  MISS},
      '{ACT_LOAD,  10'd2,    -32'sd5,        1'b0, CHK_NONE,  MISS},
      '{ACT_LOAD,  10'd3,    -32'sd1,        1'b0, CHK_NONE,  MISS},
      '{ACT_LOAD,  10'd4,    MAX_VAL,        1'b1, CHK_NONE,  MISS},
      '{ACT_QUERY, 10'd0,    MIN_VAL,        1'b0, CHK_FIXED, '{1'b1, 10'd0, 10'd0}},
      '{ACT_QUERY, 10'd0,    -32'sd5,        1'b0, CHK_MODEL, MISS},
      '{ACT_QUERY, 10'd0,    -32'sd1,        1'b0, CHK_MODEL, MISS},
      '{ACT_QUERY, 10'd0,    MAX_VAL,        1'b0, CHK_FIXED, '{1'b1, 10'd4, 10'd4}},
      '{ACT_QUERY, 10'd0,    32'sd0,         1'b0, CHK_FIXED, MISS},
      '{ACT_QUERY, 10'd0,    MAX_VAL - 1,    1'b0, CHK_FIXED, MISS},
      '{ACT_LOAD,  10'd1023, 32'sh5555_5555, 1'b0, CHK_NONE,  MISS},
      '{ACT_LOAD,  10'd1022, 32'shaaaa_aaaa, 1'b0, CHK_NONE,  MISS},
      '{ACT_LOAD,  10'd2,    -32'sd5,        1'b1, CHK_NONE,  MISS},
      '{ACT_QUERY, 10'd0,    MAX_VAL,        1'b0, CHK_MODEL, MISS},
      '{ACT_QUERY, 10'd1023, -32'sd5,        1'b1, CHK_MODEL, MISS},
      '{ACT_LOAD,  10'd0,    32'sd9,         1'b0, CHK_NONE,  MISS},
      '{ACT_LOAD,  10'd1,    32'sd9,         1'b0, CHK_NONE,  MISS},
      '{ACT_LOAD,  10'd2,    32'sd9,         1'b1, CHK_NONE,  MISS},
      '{ACT_QUERY, 10'd0,    32'sd9,         1'b0, CHK_MODEL, MISS},
      '{ACT_LOAD,  10'd0,    32'sd0,         1'b1, CHK_NONE,  MISS},
      '{ACT_QUERY, 10'd0,    32'sd0,         1'b0, CHK_FIXED, '{1'b1, 10'd0, 10'd0}}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      send_item(dir_rows[r].act, dir_rows[r].idx, dir_rows[r].val, dir_rows[r].last_el,
                dir_rows[r].kind, dir_rows[r].fixed);
    end

    while (items_sent < N_DIR + RANDOM_ITEMS) begin
      if (largest_table < TABLE_DEPTH && items_sent >= N_DIR + 300)
        table_episode(TABLE_DEPTH);
      else if ($urandom_range(0, 4) == 0)
        table_episode($urandom_range(17, 100));
      else
        table_episode($urandom_range(1, 16));
    end

    in_ch.valid <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d loads and %0d queries on tables of up to %0d entries.",
             loads_sent, queries_sent, largest_table);
    $display("Queries returned %0d hits and %0d misses.", hits_seen, misses_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
src/sters_pkg.sv
src/sters_if.sv
src/sters_cmp.sv
src/sorted_table_equal_range_search_unit.sv
tb/sorted_table_equal_range_search_unit_tb.sv
